// ===== rtl/core/kmer_run_pair_count_accumulator_top_defines.svh =====
// Assertion macros used by the accumulator controller
`ifndef KMER_RUN_PAIR_COUNT_ACCUMULATOR_TOP_DEFINES_SVH
`define KMER_RUN_PAIR_COUNT_ACCUMULATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define KRPCA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("krpca same-cycle check failed");

// Next-cycle implication, checked outside reset
`define KRPCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("krpca next-cycle check failed");

`endif

// ===== rtl/core/krpca_pkg.sv =====
// Shared types, constants and index function of the run pair count accumulator
package krpca_pkg;

  localparam int NumStringsDef = 64;
  localparam int KeyW          = 64;
  localparam int IdxW          = 6;
  localparam int ValW          = 32;
  localparam int TriW          = 12;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic clr_wr;
    logic start_run;
    logic cnt_rd;
    logic cnt_upd;
    logic fl_init;
    logic list_rd_a;
    logic cnt_rd_sa;
    logic lat_ca;
    logic list_rd_b;
    logic cnt_rd_sb;
    logic mat_rd_pair;
    logic mul;
    logic mat_wr_pair;
    logic b_next;
    logic a_next;
    logic fl_end;
    logic mat_rd_user;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_done;
    logic s_ok;
    logic key_diff;
    logic run_active;
    logic last;
    logic a_end;
    logic b_last;
    logic out_free;
  } dp_sts_t;

  // Lower-triangular index: larger index picks the row
  function automatic logic [TriW-1:0] tri_index(input logic [IdxW-1:0] r,
                                                input logic [IdxW-1:0] c);
    logic [IdxW-1:0] hi;
    logic [IdxW-1:0] lo;
    logic [2*IdxW:0] prod;
    hi   = (c > r) ? c : r;
    lo   = (c > r) ? r : c;
    prod = {{(IdxW+1){1'b0}}, hi} * {{IdxW{1'b0}}, {1'b0, hi} + {{IdxW{1'b0}}, 1'b1}};
    return TriW'(prod >> 1) + {{(TriW-IdxW){1'b0}}, lo};
  endfunction

endpackage

// ===== rtl/core/krpca_datapath.sv =====
// Datapath: input word, run key, count/list/matrix memories, multiplier, output word
module krpca_datapath #(
  parameter int NUM_STRINGS = krpca_pkg::NumStringsDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  krpca_pkg::dp_cmd_t            cmd,
  output krpca_pkg::dp_sts_t            sts,
  input  logic [krpca_pkg::KeyW-1:0]    in_key_high,
  input  logic [krpca_pkg::KeyW-1:0]    in_key_low,
  input  logic [krpca_pkg::IdxW-1:0]    in_string_index,
  input  logic                          in_batch_last,
  input  logic [krpca_pkg::IdxW-1:0]    in_read_row,
  input  logic [krpca_pkg::IdxW-1:0]    in_read_col,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [krpca_pkg::ValW-1:0]    out_entry_value
);

  localparam int CntDepth   = (NUM_STRINGS < 64) ? NUM_STRINGS : 64;
  localparam int CntAw      = $clog2(CntDepth);
  localparam int PairDepth  = CntDepth * (CntDepth + 1) / 2;
  localparam int MatAw      = $clog2(PairDepth);
  localparam int ListAw     = $clog2(NUM_STRINGS);
  localparam int TotW       = $clog2(NUM_STRINGS + 1);
  localparam int KW         = krpca_pkg::KeyW;
  localparam int IW         = krpca_pkg::IdxW;
  localparam int VW         = krpca_pkg::ValW;
  localparam int TW         = krpca_pkg::TriW;

  // Captured input word
  logic [KW-1:0]    key_hi_r, key_lo_r;
  logic [IW-1:0]    s_r, row_r, col_r;
  logic             last_r;

  // Run state
  logic [KW-1:0]    run_hi_r, run_lo_r;
  logic             run_active_r;
  logic [TotW-1:0]  total_r;

  // Memories
  logic [VW-1:0]     cnt_mem  [CntDepth];
  logic              cnt_vld_r[CntDepth];
  logic [CntAw-1:0]  list_mem [NUM_STRINGS];
  logic [VW-1:0]     mat_mem  [PairDepth];

  logic [VW-1:0]     cnt_q;
  logic              cnt_vq_r;
  logic [CntAw-1:0]  list_q;
  logic [VW-1:0]     mat_q;

  // Walk registers
  logic [TotW-1:0]   a_r, b_r;
  logic [CntAw-1:0]  sa_r, sb_r;
  logic [VW-1:0]     ca_r, cb_r, prod_r;
  logic [MatAw-1:0]  clr_r;
  logic              rd_ok_r;

  // Output word
  logic              out_valid_r;
  logic [VW-1:0]     out_value_r;

  logic [CntAw-1:0]  s_idx;
  logic [CntAw-1:0]  cnt_addr;
  logic [TotW-1:0]   list_addr;
  logic [VW-1:0]     cnt_val;
  logic [TW-1:0]     pair_tri, user_tri;
  logic [MatAw-1:0]  mat_raddr, mat_waddr;
  logic [VW-1:0]     mat_wdata;
  logic              mat_we, mat_re;

  assign s_idx     = s_r[CntAw-1:0];
  assign cnt_val   = cnt_vq_r ? cnt_q : '0;
  assign pair_tri  = krpca_pkg::tri_index(IW'(sa_r), IW'(sb_r));
  assign user_tri  = krpca_pkg::tri_index(row_r, col_r);
  assign cnt_addr  = cmd.cnt_rd ? s_idx : list_q;
  assign list_addr = cmd.list_rd_b ? b_r : a_r;
  assign mat_raddr = cmd.mat_rd_user ? user_tri[MatAw-1:0] : pair_tri[MatAw-1:0];
  assign mat_re    = cmd.mat_rd_user | cmd.mat_rd_pair;
  assign mat_we    = cmd.clr_wr | cmd.mat_wr_pair;
  assign mat_waddr = cmd.clr_wr ? clr_r : pair_tri[MatAw-1:0];
  assign mat_wdata = cmd.clr_wr ? '0 : mat_q + prod_r;

  // Capture the input word
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      key_hi_r <= in_key_high;
      key_lo_r <= in_key_low;
      s_r      <= in_string_index;
      last_r   <= in_batch_last;
      row_r    <= in_read_row;
      col_r    <= in_read_col;
    end
  end

  // Run key and activity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_active_r <= 1'b0;
      run_hi_r     <= '0;
      run_lo_r     <= '0;
    end else if (cmd.fl_end) begin
      run_active_r <= 1'b0;
    end else if (cmd.start_run && !run_active_r) begin
      run_active_r <= 1'b1;
      run_hi_r     <= key_hi_r;
      run_lo_r     <= key_lo_r;
    end
  end

  // Count memory: one read, one write per cycle
  always_ff @(posedge clk) begin
    if (cmd.cnt_rd || cmd.cnt_rd_sa || cmd.cnt_rd_sb) begin
      cnt_q    <= cnt_mem[cnt_addr];
      cnt_vq_r <= cnt_vld_r[cnt_addr];
    end
    if (cmd.cnt_upd) begin
      cnt_mem[s_idx] <= cnt_val + VW'(1);
    end
  end

  // Count valid bits: drop all at reset and at the end of a run
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.fl_end) begin
      for (int i = 0; i < CntDepth; i++) cnt_vld_r[i] <= 1'b0;
    end else if (cmd.cnt_upd) begin
      cnt_vld_r[s_idx] <= 1'b1;
    end
  end

  // Present list memory
  always_ff @(posedge clk) begin
    if (cmd.list_rd_a || cmd.list_rd_b) begin
      list_q <= list_mem[list_addr[ListAw-1:0]];
    end
    if (cmd.cnt_upd && cnt_val == '0 && total_r < TotW'(NUM_STRINGS)) begin
      list_mem[total_r[ListAw-1:0]] <= s_idx;
    end
  end

  // Present total
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.fl_end) begin
      total_r <= '0;
    end else if (cmd.cnt_upd && cnt_val == '0 && total_r < TotW'(NUM_STRINGS)) begin
      total_r <= total_r + TotW'(1);
    end
  end

  // Pair matrix memory
  always_ff @(posedge clk) begin
    if (mat_re) begin
      mat_q <= mat_mem[mat_raddr];
    end
    if (mat_we) begin
      mat_mem[mat_waddr] <= mat_wdata;
    end
  end

  // Clearing pass address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_r <= clr_r + MatAw'(1);
    end
  end

  // Walk pointers, pair operands and product
  always_ff @(posedge clk) begin
    if (cmd.fl_init) a_r <= '0;
    else if (cmd.a_next) a_r <= a_r + TotW'(1);
    if (cmd.lat_ca) b_r <= a_r;
    else if (cmd.b_next) b_r <= b_r + TotW'(1);
    if (cmd.cnt_rd_sa) sa_r <= list_q;
    if (cmd.cnt_rd_sb) sb_r <= list_q;
    if (cmd.lat_ca) ca_r <= cnt_val;
    if (cmd.mat_rd_pair) cb_r <= cnt_val;
    if (cmd.mul) prod_r <= VW'(ca_r * cb_r);
    if (cmd.mat_rd_user) begin
      rd_ok_r <= ({1'b0, row_r} < (IW+1)'(CntDepth)) &&
                 ({1'b0, col_r} < (IW+1)'(CntDepth));
    end
  end

  // Output word: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_value_r <= rd_ok_r ? mat_q : '0;
  end

  assign out_valid       = out_valid_r;
  assign out_entry_value = out_value_r;

  // Status
  assign sts.clr_done   = (clr_r == MatAw'(PairDepth - 1));
  assign sts.s_ok       = ({1'b0, s_r} < (IW+1)'(CntDepth));
  assign sts.key_diff   = (key_hi_r != run_hi_r) || (key_lo_r != run_lo_r);
  assign sts.run_active = run_active_r;
  assign sts.last       = last_r;
  assign sts.a_end      = (a_r == total_r);
  assign sts.b_last     = ((b_r + TotW'(1)) == total_r);
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule

// ===== rtl/core/krpca_ctrl.sv =====
// Controller: clearing pass, item dispatch and run flush walk
`include "kmer_run_pair_count_accumulator_top_defines.svh"
module krpca_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_kind,
  output logic                in_ready,
  input  krpca_pkg::dp_sts_t  sts,
  output krpca_pkg::dp_cmd_t  cmd
);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_FT_CHK = 4'd2;
  localparam logic [3:0] S_FT_RD  = 4'd3;
  localparam logic [3:0] S_FT_UPD = 4'd4;
  localparam logic [3:0] S_RD0    = 4'd5;
  localparam logic [3:0] S_RD1    = 4'd6;
  localparam logic [3:0] S_FL_A   = 4'd7;
  localparam logic [3:0] S_FL_A2  = 4'd8;
  localparam logic [3:0] S_FL_A3  = 4'd9;
  localparam logic [3:0] S_FL_B1  = 4'd10;
  localparam logic [3:0] S_FL_B2  = 4'd11;
  localparam logic [3:0] S_FL_B3  = 4'd12;
  localparam logic [3:0] S_FL_B4  = 4'd13;
  localparam logic [3:0] S_FL_B5  = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic       ret_upd_r, ret_upd_nxt;  // after flush: go on to count the held word

  // State and return flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      ret_upd_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ret_upd_r <= ret_upd_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    ret_upd_nxt = ret_upd_r;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = in_kind ? S_RD0 : S_FT_CHK;
        end
      end
      S_FT_CHK: begin
        priority if (!sts.s_ok) begin
          if (sts.last && sts.run_active) begin
            cmd.fl_init = 1'b1;
            ret_upd_nxt = 1'b0;
            state_nxt   = S_FL_A;
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (sts.run_active && sts.key_diff) begin
          cmd.fl_init = 1'b1;
          ret_upd_nxt = 1'b1;
          state_nxt   = S_FL_A;
        end else begin
          state_nxt = S_FT_RD;
        end
      end
      S_FT_RD: begin
        cmd.start_run = 1'b1;
        cmd.cnt_rd    = 1'b1;
        state_nxt     = S_FT_UPD;
      end
      S_FT_UPD: begin
        cmd.cnt_upd = 1'b1;
        if (sts.last) begin
          cmd.fl_init = 1'b1;
          ret_upd_nxt = 1'b0;
          state_nxt   = S_FL_A;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RD0: begin
        cmd.mat_rd_user = 1'b1;
        state_nxt       = S_RD1;
      end
      S_RD1: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_FL_A: begin
        if (sts.a_end) begin
          cmd.fl_end = 1'b1;
          state_nxt  = ret_upd_r ? S_FT_RD : S_IDLE;
        end else begin
          cmd.list_rd_a = 1'b1;
          state_nxt     = S_FL_A2;
        end
      end
      S_FL_A2: begin
        cmd.cnt_rd_sa = 1'b1;
        state_nxt     = S_FL_A3;
      end
      S_FL_A3: begin
        cmd.lat_ca = 1'b1;
        state_nxt  = S_FL_B1;
      end
      S_FL_B1: begin
        cmd.list_rd_b = 1'b1;
        state_nxt     = S_FL_B2;
      end
      S_FL_B2: begin
        cmd.cnt_rd_sb = 1'b1;
        state_nxt     = S_FL_B3;
      end
      S_FL_B3: begin
        cmd.mat_rd_pair = 1'b1;
        state_nxt       = S_FL_B4;
      end
      S_FL_B4: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FL_B5;
      end
      S_FL_B5: begin
        cmd.mat_wr_pair = 1'b1;
        if (sts.b_last) begin
          cmd.a_next = 1'b1;
          state_nxt  = S_FL_A;
        end else begin
          cmd.b_next = 1'b1;
          state_nxt  = S_FL_B1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `KRPCA_ASSERT_NOW(a_out_slot_free, cmd.out_load, sts.out_free)
  `KRPCA_ASSERT_NOW(a_no_take_in_clear, state_r == S_CLR, !in_ready)
  `KRPCA_ASSERT_NEXT(a_pair_loop, (state_r == S_FL_B5) && !sts.b_last, state_r == S_FL_B1)
  `KRPCA_ASSERT_NEXT(a_run_closed, cmd.fl_end, !sts.run_active)

endmodule

// ===== rtl/core/kmer_run_pair_count_accumulator_top.sv =====
// Top level: k-mer run pair count accumulator, controller plus datapath
// With no run end a feature word runs S_FT_CHK, S_FT_RD, S_FT_UPD, then S_IDLE again.
// A run end walks each pair of its present strings, a string with itself included.
// A read word reads in S_RD0, loads in S_RD1 when free; out_valid then holds for out_ready.
// After reset a clearing pass zeroes the pair matrix, one entry a cycle;
// in_ready stays low until it ends.
module kmer_run_pair_count_accumulator_top #(
  parameter int NUM_STRINGS = krpca_pkg::NumStringsDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [krpca_pkg::KeyW-1:0]    in_key_high,
  input  logic [krpca_pkg::KeyW-1:0]    in_key_low,
  input  logic [krpca_pkg::IdxW-1:0]    in_string_index,
  input  logic                          in_batch_last,
  input  logic [krpca_pkg::IdxW-1:0]    in_read_row,
  input  logic [krpca_pkg::IdxW-1:0]    in_read_col,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [krpca_pkg::ValW-1:0]    out_entry_value
);

  krpca_pkg::dp_cmd_t cmd;
  krpca_pkg::dp_sts_t sts;

  // Sequence the work
  krpca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold state and memories
  krpca_datapath #(
    .NUM_STRINGS (NUM_STRINGS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_key_high     (in_key_high),
    .in_key_low      (in_key_low),
    .in_string_index (in_string_index),
    .in_batch_last   (in_batch_last),
    .in_read_row     (in_read_row),
    .in_read_col     (in_read_col),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_entry_value (out_entry_value)
  );

endmodule
